@@ design/trial_division_prime_tester_macros.svh @@
// Assertion macros for the trial division prime tester.
// Used by the top level; needs clk and rst_n in scope at the point of use.
`ifndef TRIAL_DIVISION_PRIME_TESTER_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TESTER_MACROS_SVH
`ifndef SYNTHESIS
`define TDPT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tdpt assertion failed");
`define TDPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdpt assertion failed");
`else
`define TDPT_ASSERT(lbl, prop)
`define TDPT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ design/tdpt_pkg.sv @@
// Shared types and constants of the trial division prime tester.
// No dependencies; used by the top level.
package tdpt_pkg;

    localparam int NUMBER_WIDTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF  = 40;

    localparam int FIRST_DIVISOR = 3;
    localparam int WHEEL_START   = 5;
    localparam int STEP_SHORT    = 2;
    localparam int STEP_LONG     = 4;
    localparam int LARGEST_RESET = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCREEN,
        ST_DIVIDE,
        ST_DECIDE,
        ST_FINISH
    } tdpt_state_t;

endpackage

@@ design/tdpt_stream_if.sv @@
// Valid/ready channel interfaces of the prime tester: candidates and results.
// No dependencies.
interface tdpt_cand_if #(
    parameter int NUMBER_WIDTH = 32
);
    logic                    valid;
    logic                    ready;
    logic [NUMBER_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_result_if #(
    parameter int NUMBER_WIDTH = 32,
    parameter int COUNT_WIDTH  = 40
);
    logic                    valid;
    logic                    ready;
    logic                    prime_flag;
    logic [COUNT_WIDTH-1:0]  primes_found;
    logic [COUNT_WIDTH-1:0]  checked_total;
    logic [NUMBER_WIDTH-1:0] largest_seen;

    modport source (output valid, output prime_flag, output primes_found,
                    output checked_total, output largest_seen, input ready);
    modport sink   (input valid, input prime_flag, input primes_found,
                    input checked_total, input largest_seen, output ready);
endinterface

@@ design/trial_division_prime_tester.sv @@
// Top level of the trial division prime tester (6k +/- 1 wheel).
// Depends on tdpt_pkg, tdpt_stream_if.sv and trial_division_prime_tester_macros.svh.
//
//   channel     | dir | beat payload
//   ------------+-----+---------------------------------------------------------
//   candidates  | in  | candidate
//   results     | out | prime_flag, primes_found, checked_total, largest_seen
//
// One candidate at a time. Each trial divisor runs a bit-serial restoring
// divider and then a decide state; up to about sqrt(candidate) / 3 + 2
// divisors are tried.
// Reset sets the counters to zero and the largest prime to two; no clearing pass.
// A waiting result register does not block the search; only the final load waits.
`include "trial_division_prime_tester_macros.svh"

module trial_division_prime_tester #(
    parameter int NUMBER_WIDTH = tdpt_pkg::NUMBER_WIDTH_DEF,
    parameter int COUNT_WIDTH  = tdpt_pkg::COUNT_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    tdpt_cand_if.sink     candidates,
    tdpt_result_if.source results
);
    import tdpt_pkg::*;

    localparam int BIT_CNT_WIDTH = $clog2(NUMBER_WIDTH);

    tdpt_state_t state_reg, state_next;

    logic [NUMBER_WIDTH-1:0]  cand_reg, cand_next;
    logic [NUMBER_WIDTH-1:0]  dvsr_reg, dvsr_next;
    logic [NUMBER_WIDTH-1:0]  quot_reg, quot_next;
    logic [NUMBER_WIDTH:0]    rem_reg, rem_next;
    logic [BIT_CNT_WIDTH-1:0] bit_cnt_reg, bit_cnt_next;
    logic                     first_reg, first_next;
    logic                     step4_reg, step4_next;
    logic                     verdict_reg, verdict_next;

    logic                     res_valid_reg, res_valid_next;
    logic                     res_flag_reg, res_flag_next;
    logic [COUNT_WIDTH-1:0]   prime_cnt_reg, prime_cnt_next;
    logic [COUNT_WIDTH-1:0]   check_cnt_reg, check_cnt_next;
    logic [NUMBER_WIDTH-1:0]  largest_reg, largest_next;

    logic                     in_beat;
    logic                     out_free;
    logic [NUMBER_WIDTH:0]    rem_shift;
    logic                     rem_ge;
    logic                     quot_below;
    logic                     rem_zero;
    logic [NUMBER_WIDTH-1:0]  step_val;

    assign in_beat    = candidates.valid && candidates.ready;
    assign out_free   = !res_valid_reg || results.ready;
    assign rem_shift  = {rem_reg[NUMBER_WIDTH-1:0], quot_reg[NUMBER_WIDTH-1]};
    assign rem_ge     = rem_shift >= {1'b0, dvsr_reg};
    assign quot_below = quot_reg < dvsr_reg;
    assign rem_zero   = rem_reg == '0;
    assign step_val   = step4_reg ? NUMBER_WIDTH'(STEP_LONG) : NUMBER_WIDTH'(STEP_SHORT);

    assign candidates.ready    = state_reg == ST_IDLE;
    assign results.valid         = res_valid_reg;
    assign results.prime_flag    = res_flag_reg;
    assign results.primes_found  = prime_cnt_reg;
    assign results.checked_total = check_cnt_reg;
    assign results.largest_seen  = largest_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                    state_next = ST_SCREEN;
            end
            ST_SCREEN:
            begin
                if (cand_reg < NUMBER_WIDTH'(2) || cand_reg == NUMBER_WIDTH'(2) ||
                    cand_reg == NUMBER_WIDTH'(3) || !cand_reg[0])
                    state_next = ST_FINISH;
                else
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (bit_cnt_reg == '0)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (first_reg)
                    state_next = rem_zero ? ST_FINISH : ST_DIVIDE;
                else if (quot_below || rem_zero)
                    state_next = ST_FINISH;
                else
                    state_next = ST_DIVIDE;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cand_next      = cand_reg;
        dvsr_next      = dvsr_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        first_next     = first_reg;
        step4_next     = step4_reg;
        verdict_next   = verdict_reg;
        res_valid_next = res_valid_reg && !results.ready;
        res_flag_next  = res_flag_reg;
        prime_cnt_next = prime_cnt_reg;
        check_cnt_next = check_cnt_reg;
        largest_next   = largest_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                    cand_next = candidates.candidate;
            end
            ST_SCREEN:
            begin
                verdict_next = cand_reg == NUMBER_WIDTH'(2) || cand_reg == NUMBER_WIDTH'(3);
                dvsr_next    = NUMBER_WIDTH'(FIRST_DIVISOR);
                first_next   = 1'b1;
                step4_next   = 1'b0;
                quot_next    = cand_reg;
                rem_next     = '0;
                bit_cnt_next = BIT_CNT_WIDTH'(NUMBER_WIDTH - 1);
            end
            ST_DIVIDE:
            begin
                rem_next     = rem_ge ? rem_shift - {1'b0, dvsr_reg} : rem_shift;
                quot_next    = {quot_reg[NUMBER_WIDTH-2:0], rem_ge};
                bit_cnt_next = bit_cnt_reg - 1'b1;
            end
            ST_DECIDE:
            begin
                // divisor 3 only screens; the wheel proper checks the bound first
                if (first_reg)
                    verdict_next = 1'b0;
                else
                    verdict_next = quot_below;
                if (first_reg)
                begin
                    dvsr_next  = NUMBER_WIDTH'(WHEEL_START);
                    first_next = 1'b0;
                end
                else
                begin
                    dvsr_next  = dvsr_reg + step_val;
                    step4_next = !step4_reg;
                end
                quot_next    = cand_reg;
                rem_next     = '0;
                bit_cnt_next = BIT_CNT_WIDTH'(NUMBER_WIDTH - 1);
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_flag_next  = verdict_reg;
                    check_cnt_next = (check_cnt_reg == '1) ? check_cnt_reg
                                                           : check_cnt_reg + 1'b1;
                    if (verdict_reg)
                    begin
                        prime_cnt_next = (prime_cnt_reg == '1) ? prime_cnt_reg
                                                               : prime_cnt_reg + 1'b1;
                        if (cand_reg > largest_reg)
                            largest_next = cand_reg;
                    end
                end
            end
            default:
            begin
                res_valid_next = res_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            prime_cnt_reg <= '0;
            check_cnt_reg <= '0;
            largest_reg   <= NUMBER_WIDTH'(LARGEST_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            prime_cnt_reg <= prime_cnt_next;
            check_cnt_reg <= check_cnt_next;
            largest_reg   <= largest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg     <= cand_next;
        dvsr_reg     <= dvsr_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        bit_cnt_reg  <= bit_cnt_next;
        first_reg    <= first_next;
        step4_reg    <= step4_next;
        verdict_reg  <= verdict_next;
        res_flag_reg <= res_flag_next;
    end

    `TDPT_ASSERT_NEXT(a_busy_after_beat, in_beat, !candidates.ready)
    `TDPT_ASSERT(a_counts_order, check_cnt_reg >= prime_cnt_reg)
    `TDPT_ASSERT(a_divisor_odd, (state_reg != ST_DIVIDE) || dvsr_reg[0])
    `TDPT_ASSERT(a_largest_floor, largest_reg >= NUMBER_WIDTH'(LARGEST_RESET))

endmodule
